>>> design/tssp_pkg.sv
`default_nettype none

package tssp_pkg;

    // field widths fixed by the item formats
    localparam int TIME_W    = 32;
    localparam int LEN_W     = 16;
    localparam int RAW_W     = 12;
    localparam int VER_W     = 8;
    localparam int SEQ_W     = 16;
    localparam int COUNT_W   = 6;
    localparam int VALUE_W   = 14;
    localparam int NODE_W    = 4;
    localparam int PROD_W    = 26;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VERSION  = 2'd2;

    // input operations
    localparam logic [1:0] OP_SYNC   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_POLL   = 2'd2;

    // result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // reset values
    localparam logic [NODE_W-1:0] RESET_NODE_ID       = 4'd1;
    localparam logic [LEN_W-1:0]  RESET_SAMPLE_PERIOD = 16'd1000;
    localparam logic [VER_W-1:0]  RESET_SYNC_VERSION  = 8'd1;
    localparam logic [SEQ_W-1:0]  RESET_SEQ           = 16'd1;

    // scaling constants
    localparam logic [VALUE_W-1:0] SCALE_MUL = 14'd10000;
    localparam logic [RAW_W-1:0]   SCALE_DIV = 12'd4095;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] now_time;
        logic [RAW_W-1:0]  raw_sample;
        logic [VER_W-1:0]  sync_version;
        logic [TIME_W-1:0] sync_epoch;
        logic [LEN_W-1:0]  sync_cycle;
        logic [LEN_W-1:0]  sync_slot;
        logic [LEN_W-1:0]  sync_guard;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [SEQ_W-1:0]   pkt_seq;
        logic [TIME_W-1:0]  base_time;
        logic [COUNT_W-1:0] pkt_count;
        logic [VALUE_W-1:0] sample_value;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  base_time;
        logic [COUNT_W-1:0] count;
    } send_cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCALE,
        F_DIV,
        F_CHECK
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HDR,
        B_RD,
        B_LOAD,
        B_SMP
    } back_state_t;

    // floor(x / 4095) for x <= 4095*10000: x = 4095*q0 + (q0 + x[11:0])
    function automatic logic [VALUE_W-1:0] div_by_4095(input logic [PROD_W-1:0] x);
        logic [VALUE_W-1:0] q0;
        logic [VALUE_W:0]   r0;
        logic [1:0]         adj;
        q0  = x[PROD_W-1:RAW_W];
        r0  = (VALUE_W+1)'(x[RAW_W-1:0]) + (VALUE_W+1)'(q0);
        adj = 2'd0;
        if (r0 >= (VALUE_W+1)'(SCALE_DIV))
            adj = 2'd1;
        if (r0 >= (VALUE_W+1)'(2 * SCALE_DIV))
            adj = 2'd2;
        if (r0 >= (VALUE_W+1)'(3 * SCALE_DIV))
            adj = 2'd3;
        return q0 + VALUE_W'(adj);
    endfunction

endpackage

`default_nettype wire

>>> design/tssp_in_if.sv
`default_nettype none

interface tssp_in_if;
    logic                valid;
    logic                ready;
    tssp_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/tssp_out_if.sv
`default_nettype none

interface tssp_out_if;
    logic                valid;
    logic                ready;
    tssp_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/tssp_ram.sv
`default_nettype none

module tssp_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

>>> design/tssp_div.sv
`default_nettype none

module tssp_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tssp_pkg::TIME_W-1:0] dividend,
    input  wire logic [tssp_pkg::LEN_W-1:0]  divisor,
    output logic                             done,
    output logic      [tssp_pkg::TIME_W-1:0] quotient,
    output logic      [tssp_pkg::LEN_W-1:0]  remainder
);
    import tssp_pkg::*;

    localparam int STEP_W = $clog2(TIME_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  dsr_reg, dsr_next;

    logic [LEN_W:0]    trial;
    logic              fits;

    // one restoring step per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[TIME_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[TIME_W-2:0], fits};
            rem_next  = fits ? LEN_W'(trial - {1'b0, dsr_reg}) : LEN_W'(trial);
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

`default_nettype wire

>>> design/tssp_cmd_fifo.sv
`default_nettype none

module tssp_cmd_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire tssp_pkg::send_cmd_t  push_cmd,
    input  wire logic                 pop,
    output tssp_pkg::send_cmd_t       head_cmd,
    output logic                      empty,
    output logic                      full
);
    import tssp_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    send_cmd_t        slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic do_push, do_pop;

    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd = slots[rd_ptr_reg];
    assign empty    = fill_reg == '0;
    assign full     = fill_reg == CNT_W'(DEPTH);
endmodule

`default_nettype wire

>>> design/tssp_front.sv
`default_nettype none

module tssp_front #(
    parameter int MAX_SAMPLES = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tssp_in_if.sink                              items,
    input  wire logic                            cfg_we,
    input  wire logic [tssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tssp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            back_busy,
    input  wire logic                            cmd_full,
    output logic                                 cmd_push,
    output tssp_pkg::send_cmd_t                  cmd,
    output logic                                 ram_we,
    output logic [(MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1)-1:0] ram_waddr,
    output logic [tssp_pkg::VALUE_W-1:0]         ram_wdata
);
    import tssp_pkg::*;

    localparam int AW    = MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    front_state_t      state_reg, state_next;
    logic [NODE_W-1:0] node_id_reg, node_id_next;
    logic [LEN_W-1:0]  period_reg, period_next;
    logic [VER_W-1:0]  version_reg, version_next;
    logic [TIME_W-1:0] epoch_reg, epoch_next;
    logic [LEN_W-1:0]  cycle_reg, cycle_next;
    logic [LEN_W-1:0]  slot_reg, slot_next;
    logic [LEN_W-1:0]  guard_reg, guard_next;
    logic              synced_reg, synced_next;
    logic [TIME_W-1:0] next_time_reg, next_time_next;
    logic              started_reg, started_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [TIME_W-1:0] last_cyc_reg, last_cyc_next;
    logic [TIME_W-1:0] poll_time_reg, poll_time_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    in_item_t          d;
    logic              accept;
    logic [TIME_W-1:0] due_base;
    logic [TIME_W-1:0] due_diff;
    logic              due;
    logic              has_room;
    logic              poll_ok;
    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_quotient;
    logic [LEN_W-1:0]  div_remainder;
    logic [NODE_W-1:0] slot_index;
    logic [LEN_W+NODE_W-1:0] offset;
    logic [LEN_W+NODE_W:0]   win_lo;
    logic [LEN_W+NODE_W:0]   win_hi;
    logic [LEN_W:0]          phase_hi;
    logic                    in_slot;
    logic                    send;

    tssp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d.now_time - epoch_reg),
        .divisor  (cycle_reg),
        .done     (div_done),
        .quotient (div_quotient),
        .remainder(div_remainder)
    );

    // item classification
    always_comb
    begin
        d        = items.data;
        accept   = items.valid && items.ready;
        due_base = started_reg ? next_time_reg : d.now_time;
        due_diff = d.now_time - due_base;
        due      = !due_diff[TIME_W-1];
        has_room = count_reg < CNT_W'(MAX_SAMPLES);
        poll_ok  = synced_reg && (cycle_reg != '0) && (count_reg != '0);
    end

    // guarded slot window, no wrap
    always_comb
    begin
        slot_index = node_id_reg - NODE_W'(1);
        offset     = slot_index * slot_reg;
        win_lo     = (LEN_W+NODE_W+1)'(offset) + (LEN_W+NODE_W+1)'(guard_reg[LEN_W-1:1]);
        win_hi     = (LEN_W+NODE_W+1)'(offset) + (LEN_W+NODE_W+1)'(slot_reg);
        phase_hi   = (LEN_W+1)'(div_remainder) + (LEN_W+1)'(guard_reg[LEN_W-1:1]);
        in_slot    = ((LEN_W+NODE_W+1)'(div_remainder) >= win_lo)
                     && ((LEN_W+NODE_W+1)'(phase_hi) < win_hi);
        send       = in_slot && (div_quotient != last_cyc_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && (d.op == OP_SAMPLE) && due && has_room)
                    state_next = F_SCALE;
                else if (accept && (d.op == OP_POLL) && poll_ok)
                    state_next = F_DIV;
            end
            F_SCALE:
            begin
                if (!back_busy)
                    state_next = F_IDLE;
            end
            F_DIV:
            begin
                if (div_done)
                    state_next = F_CHECK;
            end
            F_CHECK:
            begin
                if (!send || !cmd_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        items.ready    = state_reg == F_IDLE;
        div_start      = 1'b0;
        ram_we         = (state_reg == F_SCALE) && !back_busy;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = div_by_4095(prod_reg);
        cmd_push       = (state_reg == F_CHECK) && send && !cmd_full;
        cmd.seq        = seq_reg;
        cmd.base_time  = poll_time_reg;
        cmd.count      = COUNT_W'(count_reg);

        node_id_next   = node_id_reg;
        period_next    = period_reg;
        version_next   = version_reg;
        epoch_next     = epoch_reg;
        cycle_next     = cycle_reg;
        slot_next      = slot_reg;
        guard_next     = guard_reg;
        synced_next    = synced_reg;
        next_time_next = next_time_reg;
        started_next   = started_reg;
        count_next     = count_reg;
        seq_next       = seq_reg;
        last_cyc_next  = last_cyc_reg;
        poll_time_next = poll_time_reg;
        prod_next      = prod_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NODE_ID:       node_id_next = cfg_wdata[NODE_W-1:0];
                CFG_SAMPLE_PERIOD: period_next  = cfg_wdata[LEN_W-1:0];
                CFG_SYNC_VERSION:  version_next = cfg_wdata[VER_W-1:0];
                default:           ;
            endcase
        end

        if (accept)
        begin
            case (d.op)
                OP_SYNC:
                begin
                    if (d.sync_version == version_reg)
                    begin
                        epoch_next  = d.sync_epoch;
                        cycle_next  = d.sync_cycle;
                        slot_next   = d.sync_slot;
                        guard_next  = d.sync_guard;
                        synced_next = 1'b1;
                    end
                end
                OP_SAMPLE:
                begin
                    started_next   = 1'b1;
                    next_time_next = due ? due_base + TIME_W'(period_reg) : due_base;
                    prod_next      = PROD_W'(d.raw_sample) * PROD_W'(SCALE_MUL);
                end
                OP_POLL:
                begin
                    poll_time_next = d.now_time;
                    div_start      = poll_ok;
                end
                default: ;
            endcase
        end

        if (ram_we)
            count_next = count_reg + CNT_W'(1);

        if (cmd_push)
        begin
            count_next    = '0;
            seq_next      = seq_reg + SEQ_W'(1);
            last_cyc_next = div_quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            node_id_reg   <= RESET_NODE_ID;
            period_reg    <= RESET_SAMPLE_PERIOD;
            version_reg   <= RESET_SYNC_VERSION;
            epoch_reg     <= '0;
            cycle_reg     <= '0;
            slot_reg      <= '0;
            guard_reg     <= '0;
            synced_reg    <= 1'b0;
            next_time_reg <= '0;
            started_reg   <= 1'b0;
            count_reg     <= '0;
            seq_reg       <= RESET_SEQ;
            last_cyc_reg  <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            node_id_reg   <= node_id_next;
            period_reg    <= period_next;
            version_reg   <= version_next;
            epoch_reg     <= epoch_next;
            cycle_reg     <= cycle_next;
            slot_reg      <= slot_next;
            guard_reg     <= guard_next;
            synced_reg    <= synced_next;
            next_time_reg <= next_time_next;
            started_reg   <= started_next;
            count_reg     <= count_next;
            seq_reg       <= seq_next;
            last_cyc_reg  <= last_cyc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        poll_time_reg <= poll_time_next;
        prod_reg      <= prod_next;
    end
endmodule

`default_nettype wire

>>> design/tssp_back.sv
`default_nettype none

module tssp_back #(
    parameter int MAX_SAMPLES = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tssp_out_if.source                        results,
    input  wire logic                         cmd_empty,
    input  wire tssp_pkg::send_cmd_t          head_cmd,
    output logic                              cmd_pop,
    output logic                              ram_re,
    output logic [(MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1)-1:0] ram_raddr,
    input  wire logic [tssp_pkg::VALUE_W-1:0] ram_rdata,
    output logic                              busy
);
    import tssp_pkg::*;

    localparam int AW = MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1;

    back_state_t state_reg, state_next;
    send_cmd_t   cmd_reg, cmd_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        valid_reg, valid_next;
    out_item_t   item_reg, item_next;
    logic        is_last;

    always_comb
    begin
        is_last    = (COUNT_W'(idx_reg) + COUNT_W'(1)) == cmd_reg.count;
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                    state_next = B_HDR;
            end
            B_HDR:
            begin
                if (results.ready)
                    state_next = B_RD;
            end
            B_RD:   state_next = B_LOAD;
            B_LOAD: state_next = B_SMP;
            B_SMP:
            begin
                if (results.ready)
                    state_next = is_last ? B_IDLE : B_RD;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop    = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop                = 1'b1;
                    cmd_next               = head_cmd;
                    idx_next               = '0;
                    valid_next             = 1'b1;
                    item_next.kind         = KIND_HEADER;
                    item_next.pkt_seq      = head_cmd.seq;
                    item_next.base_time    = head_cmd.base_time;
                    item_next.pkt_count    = head_cmd.count;
                    item_next.sample_value = '0;
                    item_next.last         = 1'b0;
                end
            end
            B_HDR:
            begin
                if (results.ready)
                    valid_next = 1'b0;
            end
            B_RD:
            begin
                ram_re = 1'b1;
            end
            B_LOAD:
            begin
                valid_next             = 1'b1;
                item_next.kind         = KIND_SAMPLE;
                item_next.sample_value = ram_rdata;
                item_next.last         = is_last;
            end
            B_SMP:
            begin
                if (results.ready)
                begin
                    valid_next = 1'b0;
                    idx_next   = idx_reg + AW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        item_reg <= item_next;
    end

    assign results.valid = valid_reg;
    assign results.data  = item_reg;
    assign busy          = (state_reg != B_IDLE) || !cmd_empty;
endmodule

`default_nettype wire

>>> design/tdma_slot_sample_packetizer_core.sv
`default_nettype none

// channel   dir   handshake        payload
// items     in    valid / ready    op, now_time, raw_sample, sync_* fields
// results   out   valid / ready    kind, pkt_seq, base_time, pkt_count,
//                                  sample_value, last
// cfg       in    cfg_we only      cfg_index, cfg_wdata (16 bit)
//
// sync, unused ops and samples that are not stored are handled on acceptance; a stored sample
// takes a scale multiply, then divide by 4095 and buffer write, held off while a packet drains
// a poll with a schedule and buffered samples runs the 32-step serial divider for cycle/phase,
// then checks the slot and waits for room to queue a send; any other poll is handled on acceptance
// a packet drains as a header, then a read, load and send per sample, plus any stall on results
// rst_n clears all control state, the sample buffer is not cleared

module tdma_slot_sample_packetizer_core #(
    parameter int MAX_SAMPLES = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tssp_in_if.sink                              items,
    tssp_out_if.source                           results,
    input  wire logic                            cfg_we,
    input  wire logic [tssp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tssp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tssp_pkg::*;

    localparam int AW = MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1;

    // front to queue
    logic          cmd_push;
    send_cmd_t     push_cmd;
    logic          cmd_full;

    // queue to back
    logic          cmd_pop;
    logic          cmd_empty;
    send_cmd_t     head_cmd;
    logic          back_busy;

    // sample buffer ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // front: classifies items, keeps schedule and sample timing, checks the slot
    tssp_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .back_busy (back_busy),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    // send commands waiting for the back end
    tssp_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .empty    (cmd_empty),
        .full     (cmd_full)
    );

    // scaled sample buffer
    tssp_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_SAMPLES)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back: header then one item per buffered sample
    tssp_back #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .results   (results),
        .cmd_empty (cmd_empty),
        .head_cmd  (head_cmd),
        .cmd_pop   (cmd_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .busy      (back_busy)
    );
endmodule

`default_nettype wire

>>> tb/sv/tdma_slot_sample_packetizer_core_test.sv
`timescale 1ns / 100ps

module tdma_slot_sample_packetizer_core_test;

    import tssp_pkg::*;

    localparam int MAX_SAMPLES = 32;
    // time for the block to finish an item that sends nothing, such as a poll through the divider
    localparam int SETTLE      = 100;
    // worst case: 33 results per poll, each behind the longest receiver stall, plus gaps
    localparam int LIMIT       = 1000000;
    localparam int ITEMS_PER_PHASE = 30;

    // how a directed row is checked
    localparam int PREDICT    = -1;  // expectations come from the predictor
    localparam int SENDS_NONE = 0;   // no result expected
    localparam int SENDS_ONE  = 2;   // typed header plus one typed sample

    typedef struct {
        in_item_t    item;
        int          fixed_n;
        logic [15:0] fixed_seq;
        logic [13:0] fixed_val;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tssp_in_if  items_if ();
    tssp_out_if results_if ();

    tdma_slot_sample_packetizer_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register copies
    logic [3:0]  cfg_node;
    logic [15:0] cfg_period;
    logic [7:0]  cfg_version;

    // schedule and sampler state as the block should hold it
    logic [31:0] sched_epoch;
    logic [15:0] sched_cycle;
    logic [15:0] sched_slot;
    logic [15:0] sched_guard;
    bit          synced;
    logic [31:0] due_time;
    bit          sampling_on;
    logic [13:0] smp_buf [MAX_SAMPLES];
    int          buf_count;
    logic [15:0] seq_next;
    logic [31:0] last_cycle;

    out_item_t packet_q[$];          // results of the item just accepted
    out_item_t pending_results[$];   // results still owed by the block

    int          errors;
    int          cycles;
    int          phase_items;
    bit          tx_calm;            // sender runs without gaps
    bit          rx_calm;            // receiver runs without stalls
    logic [31:0] wall;               // microsecond time the stimulus has reached

    // ------------------------------------------------------------------
    // clock, cycle count and timeout
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        wait (cycles >= LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // fills packet_q with what one accepted item makes the block send
    function automatic void predict_packet(input in_item_t it);
        logic [31:0] rel;
        logic [31:0] phase;
        logic [31:0] cyc;
        logic [31:0] lag;
        logic [63:0] offset;
        logic [63:0] half;
        packet_q.delete();
        case (it.op)
            OP_SYNC:
            begin
                // only the expected version loads the schedule
                if (it.sync_version == cfg_version)
                begin
                    sched_epoch = it.sync_epoch;
                    sched_cycle = it.sync_cycle;
                    sched_slot  = it.sync_slot;
                    sched_guard = it.sync_guard;
                    synced      = 1'b1;
                end
            end
            OP_SAMPLE:
            begin
                // first sample item starts the sample clock
                if (!sampling_on)
                begin
                    due_time    = it.now_time;
                    sampling_on = 1'b1;
                end
                // due when the wrapped difference is not negative
                lag = it.now_time - due_time;
                if (!lag[31])
                begin
                    if (buf_count < MAX_SAMPLES)
                    begin
                        smp_buf[buf_count] =
                            14'((32'(it.raw_sample) * 32'd10000) / 32'd4095);
                        buf_count++;
                    end
                    due_time = due_time + 32'(cfg_period);
                end
            end
            OP_POLL:
            begin
                if (synced && sched_cycle != 16'd0)
                begin
                    rel    = it.now_time - sched_epoch;
                    phase  = rel % 32'(sched_cycle);
                    cyc    = rel / 32'(sched_cycle);
                    // node zero wraps to slot fifteen
                    offset = 64'(4'(cfg_node - 4'd1)) * 64'(sched_slot);
                    half   = 64'(sched_guard >> 1);
                    // guarded window, no wrap, may be empty
                    if (64'(phase) >= offset + half &&
                        64'(phase) + half < offset + 64'(sched_slot) &&
                        cyc != last_cycle && buf_count != 0)
                    begin
                        packet_q.push_back('{kind: KIND_HEADER, pkt_seq: seq_next,
                            base_time: it.now_time, pkt_count: 6'(buf_count),
                            sample_value: '0, last: 1'b0});
                        for (int i = 0; i < buf_count; i++)
                        begin
                            packet_q.push_back('{kind: KIND_SAMPLE, pkt_seq: seq_next,
                                base_time: it.now_time, pkt_count: 6'(buf_count),
                                sample_value: smp_buf[i], last: (i == buf_count - 1)});
                        end
                        seq_next   = seq_next + 16'd1;
                        buf_count  = 0;
                        last_cycle = cyc;
                    end
                end
            end
            default:
            begin
                // unused op, nothing happens
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report(input string what, input logic [31:0] want,
                          input logic [31:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                 $time, what, want, got);
    endtask

    out_item_t got_item;
    out_item_t want_item;

    always @(posedge clk)
    begin
        if (results_if.valid && results_if.ready)
        begin
            got_item = results_if.data;
            if (pending_results.size() == 0)
            begin
                report("unexpected result item (seq)", 32'd0, 32'(got_item.pkt_seq));
            end
            else
            begin
                want_item = pending_results.pop_front();
                if (got_item.kind != want_item.kind)
                    report("kind", 32'(want_item.kind), 32'(got_item.kind));
                if (got_item.pkt_seq != want_item.pkt_seq)
                    report("pkt_seq", 32'(want_item.pkt_seq), 32'(got_item.pkt_seq));
                if (got_item.base_time != want_item.base_time)
                    report("base_time", want_item.base_time, got_item.base_time);
                if (got_item.pkt_count != want_item.pkt_count)
                    report("pkt_count", 32'(want_item.pkt_count), 32'(got_item.pkt_count));
                if (got_item.sample_value != want_item.sample_value)
                    report("sample_value", 32'(want_item.sample_value),
                           32'(got_item.sample_value));
                if (got_item.last != want_item.last)
                    report("last", 32'(want_item.last), 32'(got_item.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // idling on both sides
    // ------------------------------------------------------------------

    // mostly none or short, now and then a long one
    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result receiver with random stalls
    initial
    begin
        int stall;
        stall = 0;
        rx_calm = 1'b0;
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (stall > 0)
            begin
                stall--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= 1'b1;
                stall = idle_len(rx_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // item and register drivers
    // ------------------------------------------------------------------

    // valid stays high between back-to-back items
    task automatic send_item(input in_item_t it, input int fixed_n,
                             input logic [15:0] fixed_seq, input logic [13:0] fixed_val);
        int n;
        n = idle_len(tx_calm);
        if (n > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.data  <= it;
        do
            @(posedge clk);
        while (!items_if.ready);
        // predictor always runs so its state follows the block
        predict_packet(it);
        if (fixed_n == PREDICT)
        begin
            foreach (packet_q[i])
                pending_results.push_back(packet_q[i]);
        end
        else if (fixed_n == SENDS_ONE)
        begin
            pending_results.push_back('{kind: KIND_HEADER, pkt_seq: fixed_seq,
                base_time: it.now_time, pkt_count: 6'd1, sample_value: '0,
                last: 1'b0});
            pending_results.push_back('{kind: KIND_SAMPLE, pkt_seq: fixed_seq,
                base_time: it.now_time, pkt_count: 6'd1, sample_value: fixed_val,
                last: 1'b1});
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_NODE_ID:       cfg_node    = value[3:0];
            CFG_SAMPLE_PERIOD: cfg_period  = value;
            CFG_SYNC_VERSION:  cfg_version = value[7:0];
            default:           ;
        endcase
    endtask

    // block idle: every result in, then time for a poll that sends nothing
    task automatic drain();
        items_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // every field random, any op
    function automatic in_item_t noise_item();
        in_item_t it;
        it.op           = 2'($urandom_range(0, 3));
        it.now_time     = $urandom();
        it.raw_sample   = 12'($urandom());
        it.sync_version = 8'($urandom());
        it.sync_epoch   = $urandom();
        it.sync_cycle   = 16'($urandom());
        it.sync_slot    = 16'($urandom());
        it.sync_guard   = 16'($urandom());
        return it;
    endfunction

    function automatic plan_row_t mk_row(input logic [1:0] op, input logic [31:0] now,
        input logic [11:0] raw, input logic [7:0] ver, input logic [31:0] epoch,
        input logic [15:0] cyc, input logic [15:0] slot, input logic [15:0] guard,
        input int fixed_n, input logic [15:0] seq = '0, input logic [13:0] val = '0);
        plan_row_t r;
        r.item      = '{op: op, now_time: now, raw_sample: raw, sync_version: ver,
                        sync_epoch: epoch, sync_cycle: cyc, sync_slot: slot,
                        sync_guard: guard};
        r.fixed_n   = fixed_n;
        r.fixed_seq = seq;
        r.fixed_val = val;
        return r;
    endfunction

    // one round: a single noise item, or else maybe a sync, a few samples and a poll mostly in our slot
    task automatic run_episode();
        in_item_t    it;
        int          nsamp;
        int          r;
        logic [31:0] rel;
        logic [63:0] offset;
        logic [63:0] half;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] c;
        tx_calm = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 99);
        // noise: any op with any content, unused op and foreign versions
        if (r < 10)
        begin
            send_item(noise_item(), PREDICT, '0, '0);
            phase_items++;
            return;
        end
        if (!synced || r < 25)
        begin
            it = noise_item();
            it.op = OP_SYNC;
            it.now_time = wall;
            it.sync_version = ($urandom_range(0, 9) == 0) ?
                cfg_version + 8'($urandom_range(1, 255)) : cfg_version;
            it.sync_slot = 16'($urandom_range(1, 4000));
            // cycle long enough to hold our slot, sometimes zero
            offset = 64'(4'(cfg_node - 4'd1)) * 64'(it.sync_slot);
            lo = offset + 64'(it.sync_slot) + 64'($urandom_range(0, 3000));
            it.sync_cycle = (lo > 64'hFFFF) ? 16'hFFFF : 16'(lo);
            if ($urandom_range(0, 9) == 0)
                it.sync_cycle = 16'd0;
            // guard mostly inside the slot, sometimes past it
            it.sync_guard = ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
                16'($urandom_range(0, it.sync_slot));
            it.sync_epoch = ($urandom_range(0, 6) == 0) ? $urandom() :
                wall - $urandom_range(0, 300000);
            send_item(it, PREDICT, '0, '0);
            phase_items++;
        end
        // now and then enough samples to overflow the buffer
        nsamp = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 36) :
            $urandom_range(0, 5);
        repeat (nsamp)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                wall = wall + 32'(cfg_period);
            else if (r < 85)
                wall = wall + $urandom_range(0, cfg_period);
            else
                wall = wall + $urandom_range(0, 200000);
            it = noise_item();
            it.op = OP_SAMPLE;
            it.now_time = wall;
            send_item(it, PREDICT, '0, '0);
            phase_items++;
        end
        // poll: mostly inside our guarded slot of a later cycle
        it = noise_item();
        it.op = OP_POLL;
        if (synced && sched_cycle != 16'd0 && $urandom_range(0, 4) != 0)
        begin
            rel    = wall - sched_epoch;
            c      = 64'(rel / 32'(sched_cycle)) + 64'd1;
            offset = 64'(4'(cfg_node - 4'd1)) * 64'(sched_slot);
            half   = 64'(sched_guard >> 1);
            lo     = offset + half;
            hi     = offset + 64'(sched_slot);
            hi     = (hi > half) ? hi - half : 64'd0;
            if (hi > 64'(sched_cycle))
                hi = 64'(sched_cycle);
            if (lo < hi)
                wall = sched_epoch + 32'(c * 64'(sched_cycle) + lo +
                    64'($urandom_range(0, 32'(hi - lo - 64'd1))));
            else
                wall = wall + $urandom_range(0, 70000);
        end
        else
        begin
            wall = wall + $urandom_range(0, 70000);
        end
        it.now_time = wall;
        send_item(it, PREDICT, '0, '0);
        phase_items++;
        // a second poll in the same cycle must stay silent once the first has sent
        if ($urandom_range(0, 3) == 0)
        begin
            it.now_time = wall + $urandom_range(0, 50);
            send_item(it, PREDICT, '0, '0);
            phase_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        plan_row_t directed[$];

        // reset values of the registers and the schedule
        cfg_node    = RESET_NODE_ID;
        cfg_period  = RESET_SAMPLE_PERIOD;
        cfg_version = RESET_SYNC_VERSION;
        sched_epoch = '0;
        sched_cycle = '0;
        sched_slot  = '0;
        sched_guard = '0;
        synced      = 1'b0;
        due_time    = '0;
        sampling_on = 1'b0;
        buf_count   = 0;
        seq_next    = RESET_SEQ;
        last_cycle  = '1;
        tx_calm     = 1'b0;
        wall        = '0;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        items_if.valid <= 1'b0;
        items_if.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part with the reset register values
        directed = '{
            // unused op with every field at its top
            mk_row(2'd3, '1, '1, '1, '1, '1, '1, '1, SENDS_NONE),
            // poll before any sync
            mk_row(OP_POLL, 32'd0, '0, '0, '0, '0, '0, '0, SENDS_NONE),
            // foreign version is ignored
            mk_row(OP_SYNC, 32'd0, '0, 8'd0, 32'd0, 16'd10000, 16'd1000, 16'd0,
                   SENDS_NONE),
            // synced but zero cycle length
            mk_row(OP_SYNC, 32'd0, '0, 8'd1, 32'd0, 16'd0, 16'd100, 16'd0, SENDS_NONE),
            // first sample sets the sample clock, full scale
            mk_row(OP_SAMPLE, 32'd100, 12'd4095, '0, '0, '0, '0, '0, SENDS_NONE),
            mk_row(OP_POLL, 32'd150, '0, '0, '0, '0, '0, '0, SENDS_NONE),
            // real schedule: window [100, 900) of every 10000
            mk_row(OP_SYNC, 32'd0, '0, 8'd1, 32'd0, 16'd10000, 16'd1000, 16'd200,
                   SENDS_NONE),
            // in the leading guard
            mk_row(OP_POLL, 32'd50, '0, '0, '0, '0, '0, '0, SENDS_NONE),
            // first edge of the window sends the one full-scale sample
            mk_row(OP_POLL, 32'd100, '0, '0, '0, '0, '0, '0, SENDS_ONE,
                   16'd1, 14'd10000),
            // same cycle again
            mk_row(OP_POLL, 32'd200, '0, '0, '0, '0, '0, '0, SENDS_NONE),
            // one microsecond early, not taken
            mk_row(OP_SAMPLE, 32'd1099, 12'd4095, '0, '0, '0, '0, '0, SENDS_NONE),
            mk_row(OP_SAMPLE, 32'd1100, 12'd0, '0, '0, '0, '0, '0, SENDS_NONE),
            mk_row(OP_SAMPLE, 32'd2100, 12'd1, '0, '0, '0, '0, '0, SENDS_NONE),
            // last microsecond of the window, next cycle
            mk_row(OP_POLL, 32'd10899, '0, '0, '0, '0, '0, '0, PREDICT),
            // trailing guard
            mk_row(OP_POLL, 32'd10900, '0, '0, '0, '0, '0, '0, SENDS_NONE),
            // half the time range away counts as early
            mk_row(OP_SAMPLE, 32'h8000_0C1C, 12'd4095, '0, '0, '0, '0, '0, SENDS_NONE),
            mk_row(OP_SAMPLE, 32'h7FFF_FFFF, 12'd2048, '0, '0, '0, '0, '0, SENDS_NONE),
            // guard wider than the slot: empty window
            mk_row(OP_SYNC, 32'd0, '0, 8'd1, 32'hFFFF_FF00, 16'hFFFF, 16'd10,
                   16'hFFFF, SENDS_NONE),
            mk_row(OP_POLL, 32'hFFFF_FF05, '0, '0, '0, '0, '0, '0, SENDS_NONE),
            // whole cycle is our slot, poll time wraps past the epoch
            mk_row(OP_SYNC, 32'd0, '0, 8'd1, 32'hFFFF_FF00, 16'hFFFF, 16'hFFFF,
                   16'd0, SENDS_NONE),
            mk_row(OP_POLL, 32'h0000_0100, '0, '0, '0, '0, '0, '0, PREDICT),
            // unused op with every field clear
            mk_row(2'd3, '0, '0, '0, '0, '0, '0, '0, SENDS_NONE)
        };
        foreach (directed[i])
            send_item(directed[i].item, directed[i].fixed_n, directed[i].fixed_seq,
                      directed[i].fixed_val);

        // random part over several register settings, extremes first
        for (int p = 0; p < 4; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_reg(CFG_NODE_ID, 16'd15);
                    write_reg(CFG_SAMPLE_PERIOD, 16'hFFFF);
                    write_reg(CFG_SYNC_VERSION, 16'hFF);
                end
                1:
                begin
                    // node zero takes the last slot, zero period takes every sample that is not early
                    write_reg(CFG_NODE_ID, 16'd0);
                    write_reg(CFG_SAMPLE_PERIOD, 16'd0);
                    write_reg(CFG_SYNC_VERSION, 16'd0);
                end
                2:
                begin
                    write_reg(CFG_NODE_ID, 16'($urandom_range(1, 15)));
                    write_reg(CFG_SAMPLE_PERIOD, 16'($urandom_range(1, 65535)));
                    write_reg(CFG_SYNC_VERSION, 16'($urandom_range(0, 255)));
                end
                default:
                begin
                    write_reg(CFG_NODE_ID, 16'd1);
                    write_reg(CFG_SAMPLE_PERIOD, 16'd1);
                    write_reg(CFG_SYNC_VERSION, 16'($urandom_range(0, 255)));
                end
            endcase
            cfg_we <= 1'b0;
            // keep sample items near the sample clock, else anywhere
            wall = sampling_on ? due_time + $urandom_range(0, 100) : $urandom();
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                run_episode();
        end

        drain();
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
